// ===== design/anp_pkg.sv =====
package anp_pkg;

	localparam int WORD_BITS_DEF   = 32;
	localparam int OFFSET_BITS_DEF = 8;
	localparam int BASE_BITS       = 6;
	localparam int MAX_RADIX       = 36;

	localparam logic [BASE_BITS-1:0] NOT_DIGIT = '1;
	localparam logic [BASE_BITS-1:0] RADIX_HEX = 6'd16;
	localparam logic [BASE_BITS-1:0] RADIX_BIN = 6'd2;
	localparam logic [BASE_BITS-1:0] RADIX_OCT = 6'd8;
	localparam logic [BASE_BITS-1:0] RADIX_DEC = 6'd10;
	// digit values of the prefix letters when they are plain digits
	localparam logic [BASE_BITS-1:0] LETTER_X_VAL = 6'd33;
	localparam logic [BASE_BITS-1:0] LETTER_B_VAL = 6'd11;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7a;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SPACE,
		PH_FIRST,
		PH_ZERO,
		PH_HEXPFX,
		PH_BINPFX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NONUM = 2'd1,
		ST_OVFL  = 2'd2
	} status_t;

	function automatic logic [BASE_BITS-1:0] digit_of(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= CH_0 && c <= CH_9) begin
				t = c - CH_0;
			end else if (c >= CH_LA && c <= CH_LZ) begin
				t = c - CH_LA + 8'd10;
			end else if (c >= CH_UA && c <= CH_UZ) begin
				t = c - CH_UA + 8'd10;
			end else begin
				t = 8'(NOT_DIGIT);
			end
			return t[BASE_BITS-1:0];
		end
	endfunction

	function automatic logic base_bad(input logic [BASE_BITS-1:0] b);
		return (b <= 6'd1) || (b > 6'(MAX_RADIX));
	endfunction

endpackage

// ===== design/anp_if.sv =====
interface anp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       start_req;

	modport source (output valid, output character, output start_req, input ready);
	modport sink (input valid, input character, input start_req, output ready);
endinterface

interface anp_out_if #(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 8
);
	logic                   valid;
	logic                   ready;
	logic [WORD_BITS-1:0]   value;
	logic [OFFSET_BITS-1:0] end_offset;
	logic [1:0]             status;

	modport source (output valid, output value, output end_offset, output status, input ready);
	modport sink (input valid, input value, input end_offset, input status, output ready);
endinterface

// ===== design/ascii_number_parser_top.sv =====
// Streaming ASCII-to-integer parser. Send one character per input transaction and set
// start_req on the first character of each string; leading white space and one sign are
// taken, then digits in number_base (2 to 36, or 0 to pick the base from a 0x, 0b or 0
// prefix). At most one result transaction leaves per string, on the character that ends
// the number; characters after it are ignored until the next start_req. One character is
// taken every cycle while the result register is free; input and result are registered,
// and the accumulator's multiply-add by the base closes on itself once per character.
// number_base is latched at start_req and may only be written while no string is in flight.
module ascii_number_parser_top #(
	parameter int WORD_BITS   = anp_pkg::WORD_BITS_DEF,
	parameter int OFFSET_BITS = anp_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [anp_pkg::BASE_BITS-1:0] cfg_wr_data,
	anp_in_if.sink                        in_ch,
	anp_out_if.source                     out_ch
);
	import anp_pkg::*;

	logic [BASE_BITS-1:0]   number_base_q;
	logic                   s1_valid;
	logic [7:0]             char_s1;
	logic                   start_s1;
	logic                   out_free;
	logic                   adv;
	logic                   res_valid;
	logic [WORD_BITS-1:0]   res_value;
	logic [OFFSET_BITS-1:0] res_offset;
	status_t                res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
		end else if (cfg_wr_en) begin
			number_base_q <= cfg_wr_data;
		end
	end

	// a character moves on only when the result register can take its outcome
	assign adv = s1_valid && out_free;

	anp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.adv      (adv),
		.s1_valid (s1_valid),
		.char_s1  (char_s1),
		.start_s1 (start_s1)
	);

	anp_step #(
		.WORD_BITS   (WORD_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.char_s1     (char_s1),
		.start_s1    (start_s1),
		.number_base (number_base_q),
		.res_valid   (res_valid),
		.res_value   (res_value),
		.res_offset  (res_offset),
		.res_status  (res_status)
	);

	anp_out_stage #(
		.WORD_BITS   (WORD_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && res_valid),
		.value      (res_value),
		.end_offset (res_offset),
		.status     (res_status),
		.free       (out_free),
		.out_ch     (out_ch)
	);

endmodule

// ===== design/anp_in_stage.sv =====
module anp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	anp_in_if.sink     in_ch,
	input  logic       adv,
	output logic       s1_valid,
	output logic [7:0] char_s1,
	output logic       start_s1
);
	logic valid_s1;

	assign in_ch.ready = !valid_s1 || adv;
	assign s1_valid    = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1  <= in_ch.character;
			start_s1 <= in_ch.start_req;
		end
	end

endmodule

// ===== design/anp_step.sv =====
module anp_step #(
	parameter int WORD_BITS   = anp_pkg::WORD_BITS_DEF,
	parameter int OFFSET_BITS = anp_pkg::OFFSET_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic [7:0]                       char_s1,
	input  logic                             start_s1,
	input  logic [anp_pkg::BASE_BITS-1:0]    number_base,
	output logic                             res_valid,
	output logic [WORD_BITS-1:0]             res_value,
	output logic [OFFSET_BITS-1:0]           res_offset,
	output anp_pkg::status_t                 res_status
);
	import anp_pkg::*;

	localparam int PW = WORD_BITS + BASE_BITS;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	phase_t                 phase_q,   cur_ph,   nxt_ph;
	logic [WORD_BITS-1:0]   acc_q,     cur_acc,  nxt_acc;
	logic [BASE_BITS-1:0]   base_q,    cur_b,    nxt_b;
	logic                   minus_q,   cur_minus, nxt_minus;
	logic                   ovf_q,     cur_ovf,  nxt_ovf;
	logic [OFFSET_BITS-1:0] pos_q,     cur_pos,  nxt_pos;

	logic [BASE_BITS-1:0] d;
	logic [PW-1:0]        mac;
	logic                 is_ws;
	logic                 is_sign;
	logic                 is_x;
	logic                 is_b;
	logic [BASE_BITS-1:0] radix;
	logic [BASE_BITS-1:0] lv;
	logic [BASE_BITS-1:0] b;

	assign d       = digit_of(char_s1);
	assign is_ws   = (char_s1 == CH_SPACE) || (char_s1 >= CH_TAB && char_s1 <= CH_CR);
	assign is_sign = (char_s1 == CH_PLUS) || (char_s1 == CH_MINUS);
	assign is_x    = (char_s1 == CH_LX) || (char_s1 == CH_UX);
	assign is_b    = (char_s1 == CH_LB) || (char_s1 == CH_UB);
	assign radix   = is_x ? RADIX_HEX : RADIX_BIN;
	assign lv      = is_x ? LETTER_X_VAL : LETTER_B_VAL;

	// accumulator feedback, one multiply-add per character
	assign mac = PW'(acc_q) * PW'(base_q) + PW'(d);

	always_comb begin
		cur_ph    = start_s1 ? PH_SPACE : phase_q;
		cur_acc   = start_s1 ? '0 : acc_q;
		cur_b     = start_s1 ? number_base : base_q;
		cur_minus = start_s1 ? 1'b0 : minus_q;
		cur_ovf   = start_s1 ? 1'b0 : ovf_q;
		cur_pos   = start_s1 ? '0 : pos_q;

		nxt_ph     = cur_ph;
		nxt_acc    = cur_acc;
		nxt_b      = cur_b;
		nxt_minus  = cur_minus;
		nxt_ovf    = cur_ovf;
		nxt_pos    = cur_pos;
		res_valid  = 1'b0;
		res_value  = '0;
		res_offset = '0;
		res_status = ST_OK;
		b          = cur_b;

		case (cur_ph)
			PH_SPACE, PH_FIRST: begin
				if (cur_ph == PH_SPACE && is_ws) begin
					nxt_ph = PH_SPACE;
				end else if (cur_ph == PH_SPACE && is_sign) begin
					nxt_minus = (char_s1 == CH_MINUS);
					nxt_ph    = PH_FIRST;
				end else if (char_s1 == CH_0) begin
					nxt_ph = PH_ZERO;
				end else begin
					if (char_s1 >= CH_1 && char_s1 <= CH_9 && cur_b == '0) begin
						b = RADIX_DEC;
					end else if (base_bad(cur_b) || d >= cur_b) begin
						res_valid  = 1'b1;
						res_status = ST_NONUM;
					end
					nxt_b   = b;
					nxt_acc = WORD_BITS'(d);
					nxt_ph  = PH_DIGITS;
				end
			end
			PH_ZERO: begin
				if (is_x || is_b) begin
					if (cur_b == '0) begin
						b = radix;
					end else if (base_bad(cur_b)) begin
						res_valid  = 1'b1;
						res_status = ST_NONUM;
					end
					nxt_b = b;
					if (!res_valid) begin
						if (b == radix) begin
							nxt_ph = is_x ? PH_HEXPFX : PH_BINPFX;
						end else if (lv >= b) begin
							// letter ends a plain zero
							res_valid  = 1'b1;
							res_offset = cur_pos;
						end else begin
							nxt_acc = WORD_BITS'(lv);
							nxt_ph  = PH_DIGITS;
						end
					end
				end else begin
					if (cur_b == '0) begin
						b = RADIX_OCT;
					end else if (base_bad(cur_b)) begin
						res_valid  = 1'b1;
						res_status = ST_NONUM;
					end
					nxt_b = b;
					if (!res_valid) begin
						if (d >= b) begin
							res_valid  = 1'b1;
							res_offset = cur_pos;
						end else begin
							nxt_acc = WORD_BITS'(d);
							nxt_ph  = PH_DIGITS;
						end
					end
				end
			end
			PH_HEXPFX, PH_BINPFX: begin
				if (d >= ((cur_ph == PH_HEXPFX) ? RADIX_HEX : RADIX_BIN)) begin
					// prefix letter was not followed by a digit: number is the zero
					res_valid  = 1'b1;
					res_offset = cur_pos - 1'b1;
				end else begin
					nxt_acc = WORD_BITS'(d);
					nxt_ph  = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (d >= cur_b) begin
					res_valid  = 1'b1;
					res_offset = cur_pos;
					if (cur_ovf) begin
						res_value  = '1;
						res_status = ST_OVFL;
					end else begin
						res_value = cur_minus ? (WORD_BITS'(0) - cur_acc) : cur_acc;
					end
				end else if (!cur_ovf) begin
					if (|mac[PW-1:WORD_BITS]) begin
						nxt_ovf = 1'b1;
					end else begin
						nxt_acc = mac[WORD_BITS-1:0];
					end
				end
			end
			default: begin
				nxt_ph = cur_ph;
			end
		endcase

		if (res_valid) begin
			nxt_ph = PH_DONE;
		end
		if (cur_ph != PH_IDLE && cur_ph != PH_DONE && cur_pos != OFFSET_MAX) begin
			nxt_pos = cur_pos + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			base_q  <= '0;
			minus_q <= 1'b0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
		end else if (adv) begin
			phase_q <= nxt_ph;
			acc_q   <= nxt_acc;
			base_q  <= nxt_b;
			minus_q <= nxt_minus;
			ovf_q   <= nxt_ovf;
			pos_q   <= nxt_pos;
		end
	end

	a_ovfl_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_OVFL |-> &res_value)
		else $error("overflow result is not saturated");

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_valid |=> phase_q == PH_DONE)
		else $error("parser did not finish after a result");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !(adv && start_s1) |=> ovf_q)
		else $error("overflow flag dropped within a string");

	a_digits_base_ok: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGITS |-> !base_bad(base_q))
		else $error("digit scan running with an invalid base");

endmodule

// ===== design/anp_out_stage.sv =====
module anp_out_stage #(
	parameter int WORD_BITS   = anp_pkg::WORD_BITS_DEF,
	parameter int OFFSET_BITS = anp_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [WORD_BITS-1:0]   value,
	input  logic [OFFSET_BITS-1:0] end_offset,
	input  anp_pkg::status_t       status,
	output logic                   free,
	anp_out_if.source              out_ch
);
	import anp_pkg::*;

	logic                   valid_q;
	logic [WORD_BITS-1:0]   value_q;
	logic [OFFSET_BITS-1:0] offset_q;
	status_t                status_q;

	assign free              = !valid_q || out_ch.ready;
	assign out_ch.valid      = valid_q;
	assign out_ch.value      = value_q;
	assign out_ch.end_offset = offset_q;
	assign out_ch.status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= value;
			offset_q <= end_offset;
			status_q <= status;
		end
	end

endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import anp_pkg::*;

	localparam logic [63:0] WORD_LIMIT = 64'hFFFF_FFFF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned CHARS_PER_THIRD = 500;

	typedef struct packed {
		logic [7:0] character;
		logic       start_req;
	} text_char_t;

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  end_offset;
		status_t     status;
	} parsed_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en = 1'b0;
	logic [BASE_BITS-1:0] cfg_wr_data = '0;

	anp_in_if in_ch();
	anp_out_if #(.WORD_BITS(32), .OFFSET_BITS(8)) out_ch();

	ascii_number_parser_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	text_char_t  pending_chars[$];
	parsed_t     expected_numbers[$];
	int unsigned chars_queued = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 34;
	int unsigned recv_idle_pct = 73;

	// parser state as the block should hold it
	phase_t               scan_phase = PH_IDLE;
	logic [63:0]          acc = '0;
	logic [BASE_BITS-1:0] radix = '0;
	logic                 neg = 1'b0;
	logic                 ovf = 1'b0;
	logic [7:0]           char_pos = '0;
	logic [BASE_BITS-1:0] base_reg = '0;

	parsed_t    new_number;
	parsed_t    want;
	logic       number_done;
	text_char_t next_char;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned digit_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
		if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
		if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
		return 255;
	endfunction

	function automatic logic radix_invalid(input int unsigned b);
		return b <= 1 || b > MAX_RADIX;
	endfunction

	function automatic parsed_t finish_number(input logic [63:0] val, input logic [7:0] off,
			input status_t st);
		parsed_t r;
		r.value = val[31:0];
		r.end_offset = off;
		r.status = st;
		scan_phase = PH_DONE;
		return r;
	endfunction

	function automatic logic scan_first(input logic [7:0] c, output parsed_t res);
		int unsigned d;
		int unsigned b;
		d = digit_value(c);
		b = 32'(radix);
		res = '0;
		if (c == CH_0) begin
			scan_phase = PH_ZERO;
			return 1'b0;
		end
		if (c >= CH_1 && c <= CH_9 && b == 0) begin
			b = 10;
		end else if (radix_invalid(b) || d >= b) begin
			res = finish_number(64'd0, 8'd0, ST_NONUM);
			return 1'b1;
		end
		radix = 6'(b);
		acc = 64'(d);
		scan_phase = PH_DIGITS;
		return 1'b0;
	endfunction

	// 'x' or 'b' after a leading zero: a prefix only when it matches the base
	function automatic logic scan_prefix_letter(input int unsigned pfx_radix, input phase_t next_ph,
			output parsed_t res);
		int unsigned b;
		int unsigned lv;
		b = 32'(radix);
		lv = 32'((pfx_radix == 16) ? LETTER_X_VAL : LETTER_B_VAL);
		res = '0;
		if (b == 0) begin
			b = pfx_radix;
		end else if (radix_invalid(b)) begin
			res = finish_number(64'd0, 8'd0, ST_NONUM);
			return 1'b1;
		end
		radix = 6'(b);
		if (b == pfx_radix) begin
			scan_phase = next_ph;
			return 1'b0;
		end
		if (lv >= b) begin
			res = finish_number(64'd0, char_pos, ST_OK);
			return 1'b1;
		end
		acc = 64'(lv);
		scan_phase = PH_DIGITS;
		return 1'b0;
	endfunction

	function automatic logic predict_char(input logic [7:0] c, input logic start,
			output parsed_t res);
		int unsigned d;
		int unsigned b;
		logic hit;
		logic is_space;
		res = '0;
		hit = 1'b0;
		if (start) begin
			scan_phase = PH_SPACE;
			acc = '0;
			radix = base_reg;
			neg = 1'b0;
			ovf = 1'b0;
			char_pos = '0;
		end
		if (scan_phase == PH_IDLE || scan_phase == PH_DONE) return 1'b0;
		d = digit_value(c);
		b = 32'(radix);
		is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		case (scan_phase)
			PH_SPACE: begin
				if (c == CH_MINUS || c == CH_PLUS) begin
					neg = (c == CH_MINUS);
					scan_phase = PH_FIRST;
				end else if (!is_space) begin
					hit = scan_first(c, res);
				end
			end
			PH_FIRST: begin
				hit = scan_first(c, res);
			end
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					hit = scan_prefix_letter(16, PH_HEXPFX, res);
				end else if (c == CH_LB || c == CH_UB) begin
					hit = scan_prefix_letter(2, PH_BINPFX, res);
				end else begin
					if (b == 0) b = 8;
					if (radix_invalid(b)) begin
						res = finish_number(64'd0, 8'd0, ST_NONUM);
						hit = 1'b1;
					end else begin
						radix = 6'(b);
						if (d >= b) begin
							res = finish_number(64'd0, char_pos, ST_OK);
							hit = 1'b1;
						end else begin
							acc = 64'(d);
							scan_phase = PH_DIGITS;
						end
					end
				end
			end
			PH_HEXPFX, PH_BINPFX: begin
				// no digit after the prefix: the number is the zero before the letter
				if (d >= ((scan_phase == PH_HEXPFX) ? 16 : 2)) begin
					res = finish_number(64'd0, char_pos - 8'd1, ST_OK);
					hit = 1'b1;
				end else begin
					acc = 64'(d);
					scan_phase = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (d >= b) begin
					if (ovf) res = finish_number(WORD_LIMIT, char_pos, ST_OVFL);
					else res = finish_number(neg ? (64'd0 - acc) : acc, char_pos, ST_OK);
					hit = 1'b1;
				end else if (!ovf) begin
					if (acc > WORD_LIMIT / b || acc * b > WORD_LIMIT - d) ovf = 1'b1;
					else acc = acc * b + d;
				end
			end
			default: begin
			end
		endcase
		if (char_pos != 8'hFF) char_pos = char_pos + 8'd1;
		return hit;
	endfunction

	// input side: predict on every accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.character <= '0;
			in_ch.start_req <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				number_done = predict_char(in_ch.character, in_ch.start_req, new_number);
				if (number_done) expected_numbers.push_back(new_number);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_char = pending_chars.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.character <= next_char.character;
					in_ch.start_req <= next_char.start_req;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// output side: compare every result transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_numbers.size() == 0) begin
					$error("unexpected result: value %0h end_offset %0d status %0d",
						out_ch.value, out_ch.end_offset, out_ch.status);
					mismatch_count++;
				end else begin
					want = expected_numbers.pop_front();
					if (out_ch.value !== want.value) begin
						$error("value: expected %0h, got %0h", want.value, out_ch.value);
						mismatch_count++;
					end
					if (out_ch.end_offset !== want.end_offset) begin
						$error("end_offset: expected %0d, got %0d", want.end_offset,
							out_ch.end_offset);
						mismatch_count++;
					end
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						mismatch_count++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ascii_number_parser_top verification failed");
			$finish;
		end
	end

	task automatic push_char(input logic [7:0] c, input logic start);
		text_char_t t;
		t.character = c;
		t.start_req = start;
		pending_chars.push_back(t);
		chars_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
	endtask

	// waits until the block has drained, and then longer for strings that end without a result
	task automatic wait_idle();
		while (pending_chars.size() != 0 || in_ch.valid || expected_numbers.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_base(input logic [BASE_BITS-1:0] b);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= b;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		base_reg = b;
		@(negedge clk);
	endtask

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) return CH_0 + 8'(d);
		return (($urandom_range(0, 1) != 0) ? CH_LA : CH_UA) + 8'(d - 10);
	endfunction

	task automatic add_random_string();
		int unsigned kind;
		int unsigned eff;
		int unsigned n;
		int unsigned r;
		logic first;
		kind = $urandom_range(0, 99);
		first = 1'b1;
		if (kind < 12) begin
			// noise: random bytes, sometimes without a start
			n = $urandom_range(1, 6);
			if ($urandom_range(0, 3) == 0) first = 1'b0;
			repeat (n) begin
				push_char(8'($urandom_range(0, 255)), first);
				first = 1'b0;
			end
			return;
		end
		// leading white space, long now and then to saturate the offset
		n = (kind >= 98) ? $urandom_range(250, 262) : $urandom_range(0, 3);
		repeat (n) begin
			r = $urandom_range(0, 5);
			push_char((r == 5) ? CH_SPACE : CH_TAB + 8'(r), first);
			first = 1'b0;
		end
		r = $urandom_range(0, 2);
		if (r == 1) begin
			push_char(CH_PLUS, first);
			first = 1'b0;
		end else if (r == 2) begin
			push_char(CH_MINUS, first);
			first = 1'b0;
		end
		eff = 32'(base_reg);
		if (eff != 0 && radix_invalid(eff)) eff = 10;
		r = $urandom_range(0, 5);
		if (r <= 2) begin
			push_char(CH_0, first);
			first = 1'b0;
			if (r == 0) begin
				push_char(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX, 1'b0);
				if (eff == 0) eff = 16;
			end else if (r == 1) begin
				push_char(($urandom_range(0, 1) != 0) ? CH_LB : CH_UB, 1'b0);
				if (eff == 0) eff = 2;
			end else if (eff == 0) begin
				eff = 8;
			end
		end else if (eff == 0) begin
			eff = 10;
		end
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
		repeat (n) begin
			push_char(digit_char($urandom_range(0, eff - 1)), first);
			first = 1'b0;
		end
		// a few strings just stop and get dropped by the next start
		if ($urandom_range(0, 19) != 0) begin
			push_char(8'($urandom_range(0, 255)), first);
			repeat ($urandom_range(0, 2)) begin
				next_char.character = 8'($urandom_range(0, 255));
				next_char.start_req = 1'b0;
				pending_chars.push_back(next_char);
			end
		end
	endtask

	initial begin
		logic [BASE_BITS-1:0] base_list[10];
		int unsigned phase_idx;
		logic [BASE_BITS-1:0] b;
		base_list = '{6'd0, 6'd2, 6'd36, 6'd1, 6'd63, 6'd10, 6'd16, 6'd8, 6'd37, 6'd0};
		phase_idx = 0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_base(6'd0);
		push_char("Q", 1'b0);
		push_text("\t-0x1fZ");
		push_text("0xg");
		push_text("09");
		push_text("12");
		push_text("x");
		push_text("4294967296 ");

		for (int third = 0; third < 3; third++) begin
			if (third == 1) begin
				send_idle_pct = 73;
				recv_idle_pct = 34;
			end else if (third == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			while (chars_queued < (third + 1) * CHARS_PER_THIRD) begin
				wait_idle();
				if (phase_idx < 10 || $urandom_range(0, 1) != 0)
					b = base_list[phase_idx % 10];
				else
					b = 6'($urandom_range(0, 63));
				write_base(b);
				phase_idx++;
				repeat (12) add_random_string();
			end
		end

		wait_idle();
		if (mismatch_count == 0) begin
			$display("ascii_number_parser_top verification clean");
		end else begin
			$display("ascii_number_parser_top verification failed");
		end
		$finish;
	end

endmodule

// ===== ascii_number_parser_top.f =====
design/anp_pkg.sv
design/anp_if.sv
design/anp_in_stage.sv
design/anp_step.sv
design/anp_out_stage.sv
design/ascii_number_parser_top.sv
bench/testbench.sv
